FILE: rtl/ita_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_pkg
// Shared constants, register codes and types for the tilt/heading block.
// ----------------------------------------------------------------------------
package ita_pkg;

  // Samples are scaled by 2^GUARD before they enter the CORDIC.
  localparam int GUARD   = 6;
  localparam int TAB_LEN = 24;
  // Angle accumulator: 2^31 is pi, two spare bits for overshoot.
  localparam int ZW      = 34;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [ZW-1:0] HALF_PI_Z = 34'sd1073741824;
  localparam logic signed [ZW-1:0] PI_Z      = 34'sd2147483648;

  // round(atan(2^-i) * 2^31 / pi)
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_READY = 3'd0,
    REG_APPLY_BIAS   = 3'd1,
    REG_ACCEL_BIAS_X = 3'd2,
    REG_ACCEL_BIAS_Y = 3'd3,
    REG_ACCEL_BIAS_Z = 3'd4,
    REG_MAG_BIAS_X   = 3'd5,
    REG_MAG_BIAS_Y   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

endpackage

FILE: rtl/ita_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_front
// Config registers, request intake, bias correction and saturation.
// ----------------------------------------------------------------------------
module ita_front import ita_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [SAMPLE_BITS-1:0]        cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_x,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_y,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_z,
  input  logic signed [SAMPLE_BITS-1:0] in_mag_x,
  input  logic signed [SAMPLE_BITS-1:0] in_mag_y,
  input  q_stat_t                       q_stat,
  output logic                          push,
  output logic [5*SAMPLE_BITS:0]        push_data
);

  localparam int S = SAMPLE_BITS;

  logic                ready_r, apply_r;
  logic signed [S-1:0] bias_r [5];
  logic                vld_r;
  logic [5*S:0]        data_r;
  logic                accept;
  logic signed [S-1:0] c0, c1, c2, c3, c4;

  function automatic logic signed [S-1:0] fix(input logic signed [S-1:0] a,
                                             input logic signed [S-1:0] b,
                                             input logic en);
    logic signed [S:0] d;
    d = {a[S-1], a} - {b[S-1], b};
    if (!en) begin
      fix = a;
    end else if (d[S] != d[S-1]) begin
      fix = d[S] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
    end else begin
      fix = d[S-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r   <= 1'b0;
      apply_r   <= 1'b0;
      bias_r[0] <= '0;
      bias_r[1] <= '0;
      bias_r[2] <= '0;
      bias_r[3] <= '0;
      bias_r[4] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SENSOR_READY: ready_r   <= cfg_wdata[0];
        REG_APPLY_BIAS:   apply_r   <= cfg_wdata[0];
        REG_ACCEL_BIAS_X: bias_r[0] <= cfg_wdata;
        REG_ACCEL_BIAS_Y: bias_r[1] <= cfg_wdata;
        REG_ACCEL_BIAS_Z: bias_r[2] <= cfg_wdata;
        REG_MAG_BIAS_X:   bias_r[3] <= cfg_wdata;
        REG_MAG_BIAS_Y:   bias_r[4] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign c0 = fix(in_accel_x, bias_r[0], apply_r);
  assign c1 = fix(in_accel_y, bias_r[1], apply_r);
  assign c2 = fix(in_accel_z, bias_r[2], apply_r);
  assign c3 = fix(in_mag_x,   bias_r[3], apply_r);
  assign c4 = fix(in_mag_y,   bias_r[4], apply_r);

  assign push     = vld_r & ~q_stat.full;
  assign in_stall = vld_r & q_stat.full;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (accept) begin
      vld_r <= 1'b1;
    end else if (push) begin
      vld_r <= 1'b0;
    end
  end

  // Not ready: zero samples give zero angles, flag marks the result invalid.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (ready_r) begin
        data_r <= {1'b1, c4, c3, c2, c1, c0};
      end else begin
        data_r <= '0;
      end
    end
  end

  assign push_data = data_r;

endmodule

FILE: rtl/ita_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_queue
// Four-entry queue between intake and the angle pipeline.
// ----------------------------------------------------------------------------
module ita_queue import ita_pkg::*; #(
  parameter int DW = 81
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output q_stat_t       stat
);

  localparam int QD = 4;
  localparam int PW = $clog2(QD);

  logic [DW-1:0] mem_r [QD];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign pop_data      = mem_r[rd_ptr_r];
  assign stat.full     = (cnt_r == (PW+1)'(QD));
  assign stat.nonempty = (cnt_r != '0);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.nonempty) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(QD)) else $error("queue count out of range");
`endif

endmodule

FILE: rtl/ita_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_cordic
// Pipelined vectoring CORDIC atan2(y, x) giving a binary angle.
// ----------------------------------------------------------------------------
module ita_cordic import ita_pkg::*; #(
  parameter int W     = 25,
  parameter int NS    = 16,
  parameter int A     = 16,
  parameter bit CLAMP = 1'b0
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] y_in,
  input  logic signed [W-1:0] x_in,
  output logic signed [A-1:0] ang
);

  localparam logic signed [ZW-1:0] RND = ZW'(64'sd1 << (31 - A));

  logic signed [W-1:0]  x_r [0:NS];
  logic signed [W-1:0]  y_r [0:NS];
  logic signed [ZW-1:0] z_r [0:NS];
  logic signed [W-1:0]  x0, y0;
  logic signed [ZW-1:0] z0, zf, zr;
  logic signed [A-1:0]  ang_r;

  // Axis cases resolve directly; left half plane is pre-rotated by half pi.
  always_comb begin
    x0 = x_in;
    y0 = y_in;
    z0 = '0;
    if (y_in == '0) begin
      y0 = '0;
      z0 = x_in[W-1] ? PI_Z : '0;
    end else if (x_in == '0) begin
      y0 = '0;
      z0 = y_in[W-1] ? -HALF_PI_Z : HALF_PI_Z;
    end else if (x_in[W-1]) begin
      if (!y_in[W-1]) begin
        x0 = y_in;
        y0 = -x_in;
        z0 = HALF_PI_Z;
      end else begin
        x0 = -y_in;
        y0 = x_in;
        z0 = -HALF_PI_Z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x0;
      y_r[0] <= y0;
      z_r[0] <= z0;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    localparam logic signed [ZW-1:0] TAB = $signed({{(ZW-32){1'b0}}, ATAN_TAB[g]});
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[g] == '0) begin
          x_r[g+1] <= x_r[g];
          y_r[g+1] <= y_r[g];
          z_r[g+1] <= z_r[g];
        end else if (!y_r[g][W-1]) begin
          x_r[g+1] <= x_r[g] + (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] - (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] + TAB;
        end else begin
          x_r[g+1] <= x_r[g] - (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] + (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] - TAB;
        end
      end
    end
  end

  always_comb begin
    zf = z_r[NS];
    if (CLAMP) begin
      if (zf > HALF_PI_Z) begin
        zf = HALF_PI_Z;
      end else if (zf < -HALF_PI_Z) begin
        zf = -HALF_PI_Z;
      end
    end
    zr = zf + RND;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= zr[32-A +: A];
    end
  end

  assign ang = ang_r;

endmodule

FILE: rtl/ita_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_back
// Squares, pipelined integer square root and three CORDIC pipelines.
// ----------------------------------------------------------------------------
module ita_back import ita_pkg::*; #(
  parameter int SAMPLE_BITS   = 16,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  q_stat_t                      q_stat,
  input  logic [5*SAMPLE_BITS:0]       q_data,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_valid_res,
  output logic signed [ANGLE_BITS-1:0] out_roll_angle,
  output logic signed [ANGLE_BITS-1:0] out_pitch_angle,
  output logic signed [ANGLE_BITS-1:0] out_yaw_angle
);

  localparam int S  = SAMPLE_BITS;
  localparam int A  = ANGLE_BITS;
  localparam int QB = S + GUARD;
  localparam int NB = 2 * QB;
  localparam int RB = QB + 2;
  localparam int W  = S + GUARD + 3;
  localparam int NS = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
  localparam int D  = QB + NS + 4;
  localparam logic signed [A-1:0] QPI = A'(64'sd1 << (A - 2));

  logic          en;
  logic [D-1:0]  vld_r, flag_r;
  logic signed [S-1:0] qax, qay, qaz;
  logic [2*S-1:0] sa_r, sb_r;
  logic [5*S-1:0] smp_r [0:QB+1];
  logic [NB-1:0]  n_r [0:QB-1];
  logic [RB-1:0]  r_r [0:QB-1];
  logic [QB-1:0]  q_r [0:QB];
  logic signed [S-1:0] fax, fay, faz, fmx, fmy;
  logic signed [W-1:0] y_roll, x_roll, y_pitch, x_pitch, y_yaw, x_yaw;

  // Whole pipeline freezes only when the result register is held.
  assign en  = ~(vld_r[D-1] & out_stall);
  assign pop = en & q_stat.nonempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[D-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flag_r <= {flag_r[D-2:0], q_data[5*S]};
    end
  end

  assign qax = q_data[0 +: S];
  assign qay = q_data[S +: S];
  assign qaz = q_data[2*S +: S];

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r     <= (2*S)'(qay * qay);
      sb_r     <= (2*S)'(qaz * qaz);
      smp_r[0] <= q_data[5*S-1:0];
      n_r[0]   <= {sa_r + sb_r, {(2*GUARD){1'b0}}};
      r_r[0]   <= '0;
      q_r[0]   <= '0;
      smp_r[1] <= smp_r[0];
    end
  end

  // One root bit per stage.
  for (genvar k = 0; k < QB; k++) begin : g_sqrt
    logic [RB-1:0] rc, tr;
    logic          ge;
    assign rc = {r_r[k][RB-3:0], n_r[k][NB-1 -: 2]};
    assign tr = {q_r[k], 2'b01};
    assign ge = (rc >= tr);
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k+1]   <= {q_r[k][QB-2:0], ge};
        smp_r[k+2] <= smp_r[k+1];
      end
    end
    if (k < QB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[k+1] <= ge ? (rc - tr) : rc;
          n_r[k+1] <= n_r[k] << 2;
        end
      end
    end
  end

  assign fax = smp_r[QB+1][0 +: S];
  assign fay = smp_r[QB+1][S +: S];
  assign faz = smp_r[QB+1][2*S +: S];
  assign fmx = smp_r[QB+1][3*S +: S];
  assign fmy = smp_r[QB+1][4*S +: S];

  assign y_roll  = {{(W-S-GUARD){fay[S-1]}}, fay, {GUARD{1'b0}}};
  assign x_roll  = {{(W-S-GUARD){faz[S-1]}}, faz, {GUARD{1'b0}}};
  assign y_pitch = -{{(W-S-GUARD){fax[S-1]}}, fax, {GUARD{1'b0}}};
  assign x_pitch = $signed({{(W-QB){1'b0}}, q_r[QB]});
  assign y_yaw   = {{(W-S-GUARD){fmy[S-1]}}, fmy, {GUARD{1'b0}}};
  assign x_yaw   = {{(W-S-GUARD){fmx[S-1]}}, fmx, {GUARD{1'b0}}};

  ita_cordic #(.W(W), .NS(NS), .A(A), .CLAMP(1'b0)) u_roll (
    .clk(clk), .en(en), .y_in(y_roll), .x_in(x_roll), .ang(out_roll_angle)
  );
  ita_cordic #(.W(W), .NS(NS), .A(A), .CLAMP(1'b1)) u_pitch (
    .clk(clk), .en(en), .y_in(y_pitch), .x_in(x_pitch), .ang(out_pitch_angle)
  );
  ita_cordic #(.W(W), .NS(NS), .A(A), .CLAMP(1'b0)) u_yaw (
    .clk(clk), .en(en), .y_in(y_yaw), .x_in(x_yaw), .ang(out_yaw_angle)
  );

  assign out_valid     = vld_r[D-1];
  assign out_valid_res = flag_r[D-1];

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |->
      (out_roll_angle == '0 && out_pitch_angle == '0 && out_yaw_angle == '0))
    else $error("not-ready result carries nonzero angles");
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= QPI && out_pitch_angle >= -QPI))
    else $error("pitch outside half pi");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_yaw_angle)))
    else $error("pipeline advanced under stall");
`endif

endmodule

FILE: rtl/imu_tilt_heading_angles_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_tilt_heading_angles_core
// Roll, pitch and heading from one accelerometer triple and magnetometer x/y.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one sample request: accel x/y/z
//   and mag x/y. Result channel (out_valid/out_stall) returns one request per
//   input: out_valid_res plus roll, pitch and yaw as binary angles (2^(A-1) is
//   pi). Config port: cfg_we writes register cfg_index with cfg_wdata; write it
//   only while the block is drained.
// Throughput: one request per clock. The intake stage, a 4-entry queue and the
//   angle pipeline all advance every cycle unless the result is stalled.
// Path: from accept to result a request runs through the intake register, the
//   queue, the squares and sum registers, the square-root pipeline (one root bit
//   per stage), then the CORDIC stages and the result register.
// Reset: rst_n (sync, low) clears the config registers, so results come back
//   with out_valid_res low and zero angles until sensor_ready is written.
// Stall: a held result freezes the angle pipeline; the queue keeps filling and
//   in_stall rises only when the queue and intake register are both full.
// ----------------------------------------------------------------------------
module imu_tilt_heading_angles_core import ita_pkg::*; #(
  parameter int SAMPLE_BITS   = 16,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [SAMPLE_BITS-1:0]        cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_x,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_y,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_z,
  input  logic signed [SAMPLE_BITS-1:0] in_mag_x,
  input  logic signed [SAMPLE_BITS-1:0] in_mag_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_valid_res,
  output logic signed [ANGLE_BITS-1:0]  out_roll_angle,
  output logic signed [ANGLE_BITS-1:0]  out_pitch_angle,
  output logic signed [ANGLE_BITS-1:0]  out_yaw_angle
);

  // Queue word: ready flag on top of five corrected samples.
  localparam int DW = 5 * SAMPLE_BITS + 1;

  q_stat_t       q_stat;
  logic          push, pop;
  logic [DW-1:0] push_data, pop_data;

  // Front: config, intake register, bias correction.
  ita_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .in_mag_x(in_mag_x), .in_mag_y(in_mag_y),
    .q_stat(q_stat), .push(push), .push_data(push_data)
  );

  // Decoupling queue so intake keeps going while results wait.
  ita_queue #(.DW(DW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .stat(q_stat)
  );

  // Back: root and angle pipelines, result register.
  ita_back #(
    .SAMPLE_BITS(SAMPLE_BITS), .ANGLE_BITS(ANGLE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_stat(q_stat), .q_data(pop_data), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_valid_res(out_valid_res), .out_roll_angle(out_roll_angle),
    .out_pitch_angle(out_pitch_angle), .out_yaw_angle(out_yaw_angle)
  );

endmodule
